// ----- sv/dmm_pkg.sv -----
// ---------------------------------------------------------------------------
// dmm_pkg
// Shared sizes, codes and helpers for the dense matrix multiply block.
// ---------------------------------------------------------------------------
package dmm_pkg;

  localparam int MAX_ROWS  = 8;
  localparam int MAX_INNER = 8;
  localparam int MAX_COLS  = 8;

  localparam int DIM_W   = 4;   // config register width, holds 0..15
  localparam int IDX_W   = 3;   // row/column/inner counter width
  localparam int ADDR_W  = 6;   // store address width
  localparam int DEPTH   = 64;  // store depth
  localparam int DATA_W  = 16;  // Q4.12 element
  localparam int PROD_W  = 32;  // Q8.24 term
  localparam int ACC_W   = 36;  // Q12.24 sum
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] FUNC_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > maxv) begin
      r = DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- sv/dmm_ram.sv -----
// ---------------------------------------------------------------------------
// dmm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module dmm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/dense_matrix_multiply.sv -----
// ---------------------------------------------------------------------------
// dense_matrix_multiply
// Fixed-point GEMM: loads Q4.12 elements into left/right stores, then streams
// out the Q12.24 product matrix in row-major order.
// ---------------------------------------------------------------------------
// Load word: stored on accept. Compute word: issues rows*cols*inner reads, one
// multiply-accumulate per cycle while the output is not stalled, set by the
// single read port of each store. Each term passes the read data and product
// registers; a finished sum enters the output register. A new word is taken as
// soon as the last read of a compute is issued. Reset clears control and sets
// all three dimension registers to 8; the stores are not cleared.
module dense_matrix_multiply
  import dmm_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [DIM_W-1:0]            cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  func,
  input  logic [ADDR_W-1:0]           flat_index,
  input  logic signed [DATA_W-1:0]    element_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [ACC_W-1:0]     product_value,
  output logic [IDX_W-1:0]            out_row,
  output logic [IDX_W-1:0]            out_col,
  output logic                        last_of_run
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t state;

  logic [DIM_W-1:0] rows_in_use, inner_in_use, cols_in_use;
  logic [DIM_W-1:0] nr, nm, nc;
  logic [IDX_W-1:0] i, j, k;
  logic [ADDR_W-1:0] la, ra, rowbase;

  logic accept, adv, issue;
  logic k_end, j_end, i_end;
  logic left_we, right_we;

  logic signed [DATA_W-1:0] ld, rd;

  logic s1_valid, s1_first, s1_last, s1_end;
  logic [IDX_W-1:0] s1_row, s1_col;
  logic s2_valid, s2_first, s2_last, s2_end;
  logic [IDX_W-1:0] s2_row, s2_col;
  logic signed [PROD_W-1:0] s2_prod;

  logic signed [ACC_W-1:0] acc, acc_next;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;
  assign adv      = !out_valid || out_ready;
  assign issue    = (state == RUN) && adv;

  assign k_end = (DIM_W'(k) + DIM_W'(1)) == nm;
  assign j_end = (DIM_W'(j) + DIM_W'(1)) == nc;
  assign i_end = (DIM_W'(i) + DIM_W'(1)) == nr;

  assign left_we  = accept && (func == FUNC_LOAD_LEFT);
  assign right_we = accept && (func == FUNC_LOAD_RIGHT);

  dmm_ram #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_left (
    .clk   (clk),
    .we    (left_we),
    .waddr (flat_index),
    .wdata (element_value),
    .re    (issue),
    .raddr (la),
    .rdata (ld)
  );

  dmm_ram #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_right (
    .clk   (clk),
    .we    (right_we),
    .waddr (flat_index),
    .wdata (element_value),
    .re    (issue),
    .raddr (ra),
    .rdata (rd)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use  <= DIM_RESET;
      inner_in_use <= DIM_RESET;
      cols_in_use  <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS:  rows_in_use  <= cfg_data;
        REG_INNER: inner_in_use <= cfg_data;
        REG_COLS:  cols_in_use  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: walks i, j, k and the two read addresses
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept && func == FUNC_COMPUTE) begin
            nr      <= clamp_dim(rows_in_use, MAX_ROWS);
            nm      <= clamp_dim(inner_in_use, MAX_INNER);
            nc      <= clamp_dim(cols_in_use, MAX_COLS);
            i       <= '0;
            j       <= '0;
            k       <= '0;
            la      <= '0;
            ra      <= '0;
            rowbase <= '0;
            state   <= RUN;
          end
        end
        RUN: begin
          if (issue) begin
            if (!k_end) begin
              k  <= k + IDX_W'(1);
              la <= la + ADDR_W'(1);
              ra <= ra + ADDR_W'(nc);
            end else begin
              k <= '0;
              if (!j_end) begin
                j  <= j + IDX_W'(1);
                la <= rowbase;
                ra <= ADDR_W'(j) + ADDR_W'(1);
              end else begin
                j       <= '0;
                ra      <= '0;
                i       <= i + IDX_W'(1);
                la      <= rowbase + ADDR_W'(nm);
                rowbase <= rowbase + ADDR_W'(nm);
                if (i_end) begin
                  state <= IDLE;
                end
              end
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // stage 1: read data arrives; stage 2: registered product
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first <= (k == '0);
      s1_last  <= k_end;
      s1_end   <= k_end && j_end && i_end;
      s1_row   <= i;
      s1_col   <= j;
      s2_first <= s1_first;
      s2_last  <= s1_last;
      s2_end   <= s1_end;
      s2_row   <= s1_row;
      s2_col   <= s1_col;
      s2_prod  <= ld * rd;
    end
  end

  assign acc_next = (s2_first ? ACC_W'(0) : acc) + ACC_W'(s2_prod);

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      acc <= acc_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_last) begin
      product_value <= acc_next;
      out_row       <= s2_row;
      out_col       <= s2_col;
      last_of_run   <= s2_end;
    end
  end

  // counters stay inside the latched dimensions while issuing
  assert property (@(posedge clk) disable iff (rst)
    state == RUN |-> (DIM_W'(i) < nr) && (DIM_W'(j) < nc) && (DIM_W'(k) < nm))
    else $error("sequencer counter out of range");

  // running left address tracks row-major i*inner + k
  assert property (@(posedge clk) disable iff (rst)
    issue |-> la == ADDR_W'(int'(i) * int'(nm) + int'(k)))
    else $error("left read address mismatch");

  // running right address tracks row-major k*cols + j
  assert property (@(posedge clk) disable iff (rst)
    issue |-> ra == ADDR_W'(int'(k) * int'(nc) + int'(j)))
    else $error("right read address mismatch");

  // no word is taken while reads are being issued
  assert property (@(posedge clk) disable iff (rst)
    issue |-> !in_ready)
    else $error("input accepted during compute");

endmodule
